// ===== sv/tfst_pkg.sv =====
`default_nettype none
package tfst_pkg;

  typedef struct packed {
    logic [31:0] sip;
    logic [15:0] sport;
    logic [31:0] dip;
    logic [15:0] dport;
  } key_t;

  typedef struct packed {
    logic [15:0] half_to;
    logic [15:0] full_to;
    logic [15:0] rst_to;
    logic [15:0] fin_to;
    logic [15:0] interval;
  } cfg_t;

  // compare unit results for one slot
  typedef struct packed {
    logic fwd;
    logic rev;
    logic expired;
  } cmp_t;

  typedef struct packed {
    logic [1:0] kind;
    key_t       key;
    logic [1:0] st;
    logic       full;
  } res_t;

  localparam logic [1:0] KIND_AGED = 2'd0;
  localparam logic [1:0] KIND_NEW  = 2'd1;
  localparam logic [1:0] KIND_PKT  = 2'd2;

  localparam logic [1:0] ST_HALF = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_RST  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam logic [2:0] REG_HALF     = 3'd0;
  localparam logic [2:0] REG_FULL     = 3'd1;
  localparam logic [2:0] REG_RST      = 3'd2;
  localparam logic [2:0] REG_FIN      = 3'd3;
  localparam logic [2:0] REG_INTERVAL = 3'd4;

  localparam int FLAG_RST = 2;
  localparam int FLAG_FIN = 0;

endpackage
`default_nettype wire

// ===== sv/tfst_ram.sv =====
`default_nettype none
module tfst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== sv/tfst_cmp.sv =====
`default_nettype none
module tfst_cmp
  import tfst_pkg::*;
(
  input  wire key_t        slot_key,
  input  wire logic [1:0]  slot_st,
  input  wire logic [31:0] slot_seen,
  input  wire key_t        pkt_key,
  input  wire logic [31:0] now,
  input  wire cfg_t        cfg,
  output cmp_t             res
);
  logic [15:0] tmo;
  logic [31:0] idle;

  always_comb begin
    unique case (slot_st)
      ST_HALF: tmo = cfg.half_to;
      ST_FULL: tmo = cfg.full_to;
      ST_RST:  tmo = cfg.rst_to;
      default: tmo = cfg.fin_to;
    endcase
  end

  assign idle        = now - slot_seen;
  assign res.expired = idle >= {16'd0, tmo};
  assign res.fwd     = slot_key == pkt_key;
  assign res.rev     = (slot_key.sip == pkt_key.dip) && (slot_key.sport == pkt_key.dport) &&
                       (slot_key.dip == pkt_key.sip) && (slot_key.dport == pkt_key.sport);
endmodule
`default_nettype wire

// ===== sv/tcp_flow_state_tracker.sv =====
`default_nettype none
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------------
// in       | in_valid / in_ready  | now_sec is_tcp src_ip src_port dst_ip dst_port
//          |                      | tcp_flags
// out      | out_valid / out_ready| event_kind flow_* flow_state table_full last
// cfg      | cfg_we (no wait)     | cfg_index cfg_data
//
// An item passes through an aging scan, when one is due, and a lookup scan,
// for TCP, both through the one compare unit: every slot is read from the
// registered table memory and checked the next cycle. The sequencer then
// decides, writes, reports and flushes before it returns to idle; no new item
// is accepted until then. A packet with no aging due and no TCP goes straight
// to the flush step.
// Synchronous reset clears valid bits, last check time and the sequencer;
// no memory clearing pass is needed. A result waits in a one-item hold
// register so the final one can carry last; the sequencer stalls while
// that register and the output register are both full and out_ready is low.
module tcp_flow_state_tracker
  import tfst_pkg::*;
#(
  parameter int TABLE_ENTRIES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] now_sec,
  input  wire logic        is_tcp,
  input  wire logic [31:0] src_ip,
  input  wire logic [15:0] src_port,
  input  wire logic [31:0] dst_ip,
  input  wire logic [15:0] dst_port,
  input  wire logic [7:0]  tcp_flags,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       event_kind,
  output logic [31:0]      flow_src_ip,
  output logic [15:0]      flow_src_port,
  output logic [31:0]      flow_dst_ip,
  output logic [15:0]      flow_dst_port,
  output logic [1:0]       flow_state,
  output logic             table_full,
  output logic             last,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] LAST_IDX = CW'(TABLE_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_AGE_RD, S_AGE_CHK, S_LK_RD, S_LK_CHK, S_DECIDE,
    S_WR_F, S_WR_R, S_EMIT_C, S_EMIT_P, S_FLUSH
  } state_t;

  state_t state;
  cfg_t   cfg;

  // latched item
  logic [31:0] now;
  logic        tcp;
  key_t        pkt;
  logic [7:0]  flags;

  logic [31:0] last_check;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [CW-1:0] idx;

  // lookup scan results
  logic          f_found, r_found, free_found;
  logic [AW-1:0] f_idx, r_idx, free_idx;
  logic [1:0]    f_state;
  logic          ins, upd_r;
  logic [1:0]    final_st, r_st;

  // result hold and output registers
  res_t pend, outr;
  logic pend_v, out_last;

  // table memories
  key_t        rd_key;
  logic [1:0]  rd_st;
  logic [31:0] rd_seen;
  logic        rd_en, key_we, seen_we, st_we;
  logic [AW-1:0] st_waddr;
  logic [1:0]  st_wdata;
  cmp_t        cmp;

  logic        due, slot_v, can_emit, emit_fire, flush_fire, rst_flag, fin_flag;
  res_t        emit_data;
  logic [AW-1:0] aidx;

  assign aidx     = idx[AW-1:0];
  assign slot_v   = valid[aidx];
  assign due      = (cfg.interval != 16'd0) && ((now_sec - last_check) >= {16'd0, cfg.interval});
  assign can_emit = !pend_v || !out_valid || out_ready;
  assign rst_flag = flags[FLAG_RST];
  assign fin_flag = flags[FLAG_FIN];

  assign rd_en   = (state == S_AGE_RD) || (state == S_LK_RD);
  assign key_we  = (state == S_WR_F) && ins;
  assign seen_we = (state == S_WR_F);
  assign st_we   = (state == S_WR_F) || ((state == S_WR_R) && upd_r);
  assign st_waddr = (state == S_WR_F) ? f_idx : r_idx;
  assign st_wdata = (state == S_WR_F) ? final_st : r_st;

  tfst_ram #(.WIDTH(96), .DEPTH(TABLE_ENTRIES)) u_key (
    .clk, .we(key_we), .waddr(f_idx), .wdata(pkt), .re(rd_en), .raddr(aidx),
    .rdata(rd_key)
  );
  tfst_ram #(.WIDTH(2), .DEPTH(TABLE_ENTRIES)) u_st (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata), .re(rd_en), .raddr(aidx),
    .rdata(rd_st)
  );
  tfst_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_seen (
    .clk, .we(seen_we), .waddr(f_idx), .wdata(now), .re(rd_en), .raddr(aidx),
    .rdata(rd_seen)
  );

  tfst_cmp u_cmp (
    .slot_key(rd_key), .slot_st(rd_st), .slot_seen(rd_seen),
    .pkt_key(pkt), .now, .cfg, .res(cmp)
  );

  // result request from the sequencer
  always_comb begin
    emit_data = '{kind: KIND_PKT, key: pkt, st: final_st, full: 1'b0};
    emit_fire = 1'b0;
    unique case (state)
      S_AGE_CHK: begin
        emit_data = '{kind: KIND_AGED, key: rd_key, st: rd_st, full: 1'b0};
        emit_fire = slot_v && cmp.expired && can_emit;
      end
      S_DECIDE: begin
        emit_data = '{kind: KIND_PKT, key: pkt, st: ST_HALF, full: 1'b1};
        emit_fire = !f_found && !free_found && can_emit;
      end
      S_EMIT_C: begin
        emit_data = '{kind: KIND_NEW, key: pkt, st: ST_HALF, full: 1'b0};
        emit_fire = can_emit;
      end
      S_EMIT_P: emit_fire = can_emit;
      default: ;
    endcase
  end

  assign flush_fire = (state == S_FLUSH) && (!pend_v || !out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid      <= '0;
      last_check <= '0;
      pend_v     <= 1'b0;
      out_valid  <= 1'b0;
      cfg        <= '{half_to: 16'd60, full_to: 16'd180, rst_to: 16'd10,
                      fin_to: 16'd20, interval: 16'd1};
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_HALF:     cfg.half_to  <= cfg_data;
          REG_FULL:     cfg.full_to  <= cfg_data;
          REG_RST:      cfg.rst_to   <= cfg_data;
          REG_FIN:      cfg.fin_to   <= cfg_data;
          REG_INTERVAL: cfg.interval <= cfg_data;
          default: ;
        endcase
      end

      // output side: a held result moves out when a newer one arrives or at flush
      if ((emit_fire || flush_fire) && pend_v) begin
        outr      <= pend;
        out_last  <= flush_fire;
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (emit_fire) begin
        pend   <= emit_data;
        pend_v <= 1'b1;
      end else if (flush_fire) begin
        pend_v <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            now        <= now_sec;
            tcp        <= is_tcp;
            pkt        <= '{sip: src_ip, sport: src_port, dip: dst_ip, dport: dst_port};
            flags      <= tcp_flags;
            idx        <= '0;
            f_found    <= 1'b0;
            r_found    <= 1'b0;
            free_found <= 1'b0;
            if (due) begin
              last_check <= now_sec;
              state      <= S_AGE_RD;
            end else begin
              state <= is_tcp ? S_LK_RD : S_FLUSH;
            end
          end
        end
        S_AGE_RD: state <= S_AGE_CHK;
        S_AGE_CHK: begin
          if (!(slot_v && cmp.expired) || can_emit) begin
            if (slot_v && cmp.expired) begin
              valid[aidx] <= 1'b0;
            end
            if (idx == LAST_IDX) begin
              idx   <= '0;
              state <= tcp ? S_LK_RD : S_FLUSH;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_AGE_RD;
            end
          end
        end
        S_LK_RD: state <= S_LK_CHK;
        S_LK_CHK: begin
          // lowest matching slot wins, as does the lowest free one
          if (slot_v && cmp.fwd && !f_found) begin
            f_found <= 1'b1;
            f_idx   <= aidx;
            f_state <= rd_st;
          end
          if (slot_v && cmp.rev && !r_found) begin
            r_found <= 1'b1;
            r_idx   <= aidx;
          end
          if (!slot_v && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= aidx;
          end
          if (idx == LAST_IDX) begin
            state <= S_DECIDE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_LK_RD;
          end
        end
        S_DECIDE: begin
          r_st <= rst_flag ? ST_RST : (fin_flag ? ST_FIN : ST_FULL);
          if (f_found) begin
            ins      <= 1'b0;
            upd_r    <= r_found && (rst_flag || fin_flag);
            final_st <= rst_flag ? ST_RST : (fin_flag ? ST_FIN : f_state);
            state    <= S_WR_F;
          end else if (free_found) begin
            ins      <= 1'b1;
            f_idx    <= free_idx;
            upd_r    <= r_found;
            final_st <= rst_flag ? ST_RST :
                        (fin_flag ? ST_FIN : (r_found ? ST_FULL : ST_HALF));
            state    <= S_WR_F;
          end else if (can_emit) begin
            state <= S_FLUSH;  // table full
          end
        end
        S_WR_F: begin
          if (ins) begin
            valid[f_idx] <= 1'b1;
          end
          state <= S_WR_R;
        end
        S_WR_R: state <= ins ? S_EMIT_C : S_EMIT_P;
        S_EMIT_C: if (can_emit) state <= S_EMIT_P;
        S_EMIT_P: if (can_emit) state <= S_FLUSH;
        S_FLUSH:  if (flush_fire) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  assign in_ready      = (state == S_IDLE);
  assign event_kind    = outr.kind;
  assign flow_src_ip   = outr.key.sip;
  assign flow_src_port = outr.key.sport;
  assign flow_dst_ip   = outr.key.dip;
  assign flow_dst_port = outr.key.dport;
  assign flow_state    = outr.st;
  assign table_full    = outr.full;
  assign last          = out_last;
endmodule
`default_nettype wire

// ===== sv/tfst_checker.sv =====
`default_nettype none
module tfst_checker
  import tfst_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  event_kind,
  input wire logic [31:0] flow_src_ip,
  input wire logic        table_full,
  input wire logic        last
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(flow_src_ip) && $stable(last))
    else $error("stalled result changed");

  a_full_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> event_kind == KIND_PKT && last)
    else $error("table full result not a final packet result");

  a_new_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == KIND_NEW |-> !last)
    else $error("created result marked last");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  a_reset_ready: assert property (@(posedge clk) rst |=> in_ready && !out_valid)
    else $error("not idle after reset");
endmodule

bind tcp_flow_state_tracker tfst_checker u_tfst_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
  .event_kind, .flow_src_ip, .table_full, .last
);
`default_nettype wire
